// ===== sv/dshq_pkg.sv =====
package dshq_pkg;

    // Default field widths.
    localparam int READING_BITS_DEFAULT = 16;
    localparam int RUN_BITS_DEFAULT     = 8;

    // Configuration register widths and port widths.
    localparam int LEVEL_BITS     = 15;
    localparam int LIMIT_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 15;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_NO_TARGET_LEVEL     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STUCK_EPSILON       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAULT_RUN_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STUCK_RUN_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NO_TARGET_RUN_LIMIT = 3'd4;

    // Configuration reset values.
    localparam logic [LEVEL_BITS-1:0] NO_TARGET_LEVEL_RESET     = 15'd9999;
    localparam logic [LEVEL_BITS-1:0] STUCK_EPSILON_RESET       = 15'd2;
    localparam logic [LIMIT_BITS-1:0] FAULT_RUN_LIMIT_RESET     = 8'd3;
    localparam logic [LIMIT_BITS-1:0] STUCK_RUN_LIMIT_RESET     = 8'd12;
    localparam logic [LIMIT_BITS-1:0] NO_TARGET_RUN_LIMIT_RESET = 8'd4;

    // Reported status, in rising priority.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_TARGET = 2'd1,
        STATUS_STUCK     = 2'd2,
        STATUS_FAULT     = 2'd3
    } status_t;

    // Health grade.
    typedef enum logic [1:0] {
        HEALTH_OK      = 2'd0,
        HEALTH_WARNING = 2'd1,
        HEALTH_FAULT   = 2'd2
    } health_t;

endpackage

// ===== sv/distance_sensor_health_qualifier_core.sv =====
// Distance sensor health qualifier.
//
// The s_ channel takes one item per poll: a signed distance reading and a flag
// that says motion is expected. The m_ channel returns exactly one item per
// input item: a prioritized status (fault, stuck, no target, ok) and a health
// grade. The cfg_ channel writes the five thresholds by register index; it is
// always ready, and writes to unused indexes are dropped. Thresholds should be
// written only while no item is in flight.
//
// An accepted item is held first in the input register; the run counters
// and the status logic then update in one pass into the result register,
// from which the result is taken. One item is taken every cycle for as long
// as the receiver keeps m_ready high. When the receiver stalls, the result
// register holds its item and the input register can still take one more
// item before s_ready drops.
//
// Synchronous reset clears the run counters, the previous reading, the valid
// flags and restores the threshold defaults.
module distance_sensor_health_qualifier_core
    import dshq_pkg::*;
#(
    parameter int READING_BITS = READING_BITS_DEFAULT,
    parameter int RUN_BITS     = RUN_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [READING_BITS-1:0]  s_distance_mm,
    input  logic                            s_moving,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_health,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

    // Compare widths wide enough for both operands.
    localparam int CMP_W  = ((READING_BITS > LEVEL_BITS) ? READING_BITS : LEVEL_BITS) + 1;
    localparam int DIFF_W = READING_BITS + 1;
    localparam int EPS_W  = (DIFF_W > LEVEL_BITS) ? DIFF_W : LEVEL_BITS;
    localparam int LIM_W  = (RUN_BITS > LIMIT_BITS) ? RUN_BITS : LIMIT_BITS;

    // Saturating run counter step.
    function automatic logic [RUN_BITS-1:0] run_step(input logic hit,
                                                     input logic [RUN_BITS-1:0] run);
        logic [RUN_BITS-1:0] result;
        begin
            if (!hit) begin
                result = '0;
            end else if (run == {RUN_BITS{1'b1}}) begin
                result = run;
            end else begin
                result = run + 1'b1;
            end
            return result;
        end
    endfunction

    // Configuration registers.
    logic [LEVEL_BITS-1:0] no_target_level_reg;
    logic [LEVEL_BITS-1:0] stuck_epsilon_reg;
    logic [LIMIT_BITS-1:0] fault_run_limit_reg;
    logic [LIMIT_BITS-1:0] stuck_run_limit_reg;
    logic [LIMIT_BITS-1:0] no_target_run_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_target_level_reg     <= NO_TARGET_LEVEL_RESET;
            stuck_epsilon_reg       <= STUCK_EPSILON_RESET;
            fault_run_limit_reg     <= FAULT_RUN_LIMIT_RESET;
            stuck_run_limit_reg     <= STUCK_RUN_LIMIT_RESET;
            no_target_run_limit_reg <= NO_TARGET_RUN_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NO_TARGET_LEVEL:     no_target_level_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_STUCK_EPSILON:       stuck_epsilon_reg       <= cfg_data[LEVEL_BITS-1:0];
                REG_FAULT_RUN_LIMIT:     fault_run_limit_reg     <= cfg_data[LIMIT_BITS-1:0];
                REG_STUCK_RUN_LIMIT:     stuck_run_limit_reg     <= cfg_data[LIMIT_BITS-1:0];
                REG_NO_TARGET_RUN_LIMIT: no_target_run_limit_reg <= cfg_data[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control: the result register loads when it is empty or
    // being drained; the input register loads when empty or moving forward.
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;

    // Input register.
    logic signed [READING_BITS-1:0] in_distance_reg;
    logic                           in_moving_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_distance_reg <= s_distance_mm;
            in_moving_reg   <= s_moving;
        end
    end

    // Tracking state.
    logic signed [READING_BITS-1:0] previous_reading_reg;
    logic                           previous_valid_reg;
    logic [RUN_BITS-1:0]            unchanged_run_reg, unchanged_run_next;
    logic [RUN_BITS-1:0]            zero_run_reg, zero_run_next;
    logic [RUN_BITS-1:0]            far_run_reg, far_run_next;
    logic [RUN_BITS-1:0]            error_run_reg, error_run_next;

    // Reading classification against the thresholds.
    logic signed [CMP_W-1:0]  value_ext;
    logic signed [CMP_W-1:0]  level_ext;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic                     is_error;
    logic                     is_zero;
    logic                     is_far;
    logic                     is_close;

    always_comb begin
        value_ext = CMP_W'(in_distance_reg);
        level_ext = $signed({1'b0, (CMP_W-1)'(no_target_level_reg)});
        diff      = DIFF_W'(in_distance_reg) - DIFF_W'(previous_reading_reg);
        diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        is_error  = in_distance_reg[READING_BITS-1];
        is_zero   = (in_distance_reg == '0);
        is_far    = (value_ext >= level_ext);
        is_close  = (EPS_W'(diff_abs) <= EPS_W'(stuck_epsilon_reg));
    end

    // Run counter updates.
    always_comb begin
        error_run_next = run_step(is_error, error_run_reg);
        zero_run_next  = run_step(is_zero, zero_run_reg);
        far_run_next   = run_step(is_far, far_run_reg);
        if (!in_moving_reg) begin
            unchanged_run_next = '0;
        end else begin
            unchanged_run_next = run_step(!is_error && !is_zero && !is_far &&
                                          previous_valid_reg && is_close,
                                          unchanged_run_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_reading_reg <= '0;
            previous_valid_reg   <= 1'b0;
            unchanged_run_reg    <= '0;
            zero_run_reg         <= '0;
            far_run_reg          <= '0;
            error_run_reg        <= '0;
        end else if (out_load) begin
            previous_reading_reg <= in_distance_reg;
            previous_valid_reg   <= 1'b1;
            unchanged_run_reg    <= unchanged_run_next;
            zero_run_reg         <= zero_run_next;
            far_run_reg          <= far_run_next;
            error_run_reg        <= error_run_next;
        end
    end

    // Prioritized status from the updated counters.
    status_t status_next;
    health_t health_next;

    always_comb begin
        priority if (LIM_W'(error_run_next) >= LIM_W'(fault_run_limit_reg)) begin
            status_next = STATUS_FAULT;
            health_next = HEALTH_FAULT;
        end else if (LIM_W'(unchanged_run_next) >= LIM_W'(stuck_run_limit_reg)) begin
            status_next = STATUS_STUCK;
            health_next = HEALTH_FAULT;
        end else if (LIM_W'(zero_run_next) >= LIM_W'(no_target_run_limit_reg) ||
                     LIM_W'(far_run_next) >= LIM_W'(no_target_run_limit_reg)) begin
            status_next = STATUS_NO_TARGET;
            health_next = HEALTH_WARNING;
        end else begin
            status_next = STATUS_OK;
            health_next = HEALTH_OK;
        end
    end

    // Result register.
    status_t out_status_reg;
    health_t out_health_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= status_next;
            out_health_reg <= health_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_health = out_health_reg;

    // A waiting input item is kept until it moves into the result register.
    a_in_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> in_valid_reg)
        else $error("input item dropped while result register stalled");

    // Health grade follows the status.
    a_health_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_health == HEALTH_FAULT) ==
                     (m_status == STATUS_FAULT || m_status == STATUS_STUCK)))
        else $error("health grade does not match status");

    // Runs can only be counting once a reading has been taken.
    a_runs_need_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_run_reg != '0 || zero_run_reg != '0 || far_run_reg != '0 ||
         unchanged_run_reg != '0) |-> previous_valid_reg)
        else $error("run counter active before any reading");

    // The unchanged run never counts while motion is not expected.
    a_stuck_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !in_moving_reg) |=> (unchanged_run_reg == '0))
        else $error("unchanged run not cleared while stationary");

endmodule

// ===== dv/tb.sv =====
module tb;
    import dshq_pkg::*;

    localparam int READING_W      = READING_BITS_DEFAULT;
    localparam int RUN_W          = RUN_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [RUN_W-1:0] RUN_FULL = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_LAST = '1;

    // Kinds of reading sequences that the stimulus strings together.
    typedef enum int {
        RUN_ERROR,
        RUN_ZERO,
        RUN_FAR,
        RUN_STEADY,
        RUN_EDGE,
        RUN_NOISE
    } run_kind_t;

    typedef struct packed {
        status_t status;
        health_t health;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [READING_W-1:0] s_distance_mm = '0;
    logic                        s_moving = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    logic [1:0] m_health;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Predicted thresholds, starting from their reset values.
    logic [LEVEL_BITS-1:0] thr_level           = NO_TARGET_LEVEL_RESET;
    logic [LEVEL_BITS-1:0] thr_epsilon         = STUCK_EPSILON_RESET;
    logic [LIMIT_BITS-1:0] thr_fault_limit     = FAULT_RUN_LIMIT_RESET;
    logic [LIMIT_BITS-1:0] thr_stuck_limit     = STUCK_RUN_LIMIT_RESET;
    logic [LIMIT_BITS-1:0] thr_no_target_limit = NO_TARGET_RUN_LIMIT_RESET;

    // Predicted sensor history.
    int               pred_prev_mm = 0;
    bit               pred_prev_seen = 1'b0;
    logic [RUN_W-1:0] pred_unchanged_run = '0;
    logic [RUN_W-1:0] pred_zero_run = '0;
    logic [RUN_W-1:0] pred_far_run = '0;
    logic [RUN_W-1:0] pred_error_run = '0;

    verdict_t expected_verdicts[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int readings_sent = 0;
    int verdicts_checked = 0;
    int register_writes = 0;
    int quiet_cycles = 0;

    distance_sensor_health_qualifier_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_distance_mm(s_distance_mm),
        .s_moving     (s_moving),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_health     (m_health),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A run counter either grows, saturating at its full value, or clears.
    function automatic logic [RUN_W-1:0] extend_run(bit hit, logic [RUN_W-1:0] run);
        if (!hit) return '0;
        return (run == RUN_FULL) ? run : run + 1'b1;
    endfunction

    // Update the predicted history with one reading and queue its verdict.
    function automatic void qualify_reading(logic signed [READING_W-1:0] mm, logic mv);
        int value;
        int level;
        int diff;
        verdict_t v;
        value = mm;
        level = int'(thr_level);
        pred_error_run = extend_run(value < 0, pred_error_run);
        pred_zero_run  = extend_run(value == 0, pred_zero_run);
        pred_far_run   = extend_run(value >= level, pred_far_run);
        if (!mv) begin
            pred_unchanged_run = '0;
        end else begin
            diff = value - pred_prev_mm;
            if (diff < 0) diff = -diff;
            pred_unchanged_run = extend_run(value > 0 && value < level && pred_prev_seen &&
                                            diff <= int'(thr_epsilon), pred_unchanged_run);
        end
        pred_prev_mm = value;
        pred_prev_seen = 1'b1;

        if (pred_error_run >= thr_fault_limit) begin
            v.status = STATUS_FAULT;
            v.health = HEALTH_FAULT;
        end else if (pred_unchanged_run >= thr_stuck_limit) begin
            v.status = STATUS_STUCK;
            v.health = HEALTH_FAULT;
        end else if (pred_zero_run >= thr_no_target_limit ||
                     pred_far_run >= thr_no_target_limit) begin
            v.status = STATUS_NO_TARGET;
            v.health = HEALTH_WARNING;
        end else begin
            v.status = STATUS_OK;
            v.health = HEALTH_OK;
        end
        expected_verdicts.push_back(v);
    endfunction

    // Present one reading, after a random gap, and wait until it is taken.
    // Valid stays high on return so that a following item can go out at once.
    task automatic send_reading(input logic signed [READING_W-1:0] mm, input logic mv);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_distance_mm <= mm;
        s_moving <= mv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        qualify_reading(mm, mv);
        readings_sent++;
    endtask

    // Write one threshold register; the caller lowers valid after the last write.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_NO_TARGET_LEVEL:     thr_level = data;
            REG_STUCK_EPSILON:       thr_epsilon = data;
            REG_FAULT_RUN_LIMIT:     thr_fault_limit = data[LIMIT_BITS-1:0];
            REG_STUCK_RUN_LIMIT:     thr_stuck_limit = data[LIMIT_BITS-1:0];
            REG_NO_TARGET_RUN_LIMIT: thr_no_target_limit = data[LIMIT_BITS-1:0];
            default: ;
        endcase
        register_writes++;
    endtask

    // Stop sending and wait until every verdict is back and the pipeline is empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_verdicts.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Load all thresholds while idle; a write to an unused index goes in too.
    task automatic apply_thresholds(input logic [CFG_DATA_BITS-1:0] level,
                                    input logic [CFG_DATA_BITS-1:0] eps,
                                    input logic [CFG_DATA_BITS-1:0] fault_lim,
                                    input logic [CFG_DATA_BITS-1:0] stuck_lim,
                                    input logic [CFG_DATA_BITS-1:0] no_target_lim);
        drain_pipeline();
        write_register(REG_NO_TARGET_LEVEL, level);
        write_register(REG_STUCK_EPSILON, eps);
        write_register(REG_FAULT_RUN_LIMIT, fault_lim);
        write_register(CFG_INDEX_BITS'($urandom_range(REG_INDEX_LAST,
                                                      REG_NO_TARGET_RUN_LIMIT + 1)),
                       CFG_DATA_BITS'($urandom_range(32767)));
        write_register(REG_STUCK_RUN_LIMIT, stuck_lim);
        write_register(REG_NO_TARGET_RUN_LIMIT, no_target_lim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_limit();
        case ($urandom_range(9))
            0: return '0;
            1: return 15'd255;
            2: return CFG_DATA_BITS'($urandom_range(32767));
            default: return CFG_DATA_BITS'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic randomize_thresholds();
        logic [CFG_DATA_BITS-1:0] level;
        logic [CFG_DATA_BITS-1:0] eps;
        case ($urandom_range(7))
            0: level = '0;
            1: level = 15'd32767;
            default: level = CFG_DATA_BITS'($urandom_range(20000, 16));
        endcase
        case ($urandom_range(5))
            0: eps = '0;
            1: eps = 15'd32767;
            default: eps = CFG_DATA_BITS'($urandom_range(40));
        endcase
        apply_thresholds(level, eps, pick_limit(), pick_limit(), pick_limit());
    endtask

    // Send a sequence of readings of one kind, each with random content.
    task automatic send_run(input run_kind_t kind, input int len);
        int v;
        int e;
        int off;
        int level;
        logic mv;
        for (int k = 0; k < len; k++) begin
            level = int'(thr_level);
            e = int'(thr_epsilon);
            mv = 1'($urandom_range(1));
            case (kind)
                RUN_ERROR: v = -int'($urandom_range(32768, 1));
                RUN_ZERO:  v = 0;
                RUN_FAR:   v = $urandom_range(32767, level);
                RUN_STEADY: begin
                    // Mostly moving readings that stay within epsilon of the last one.
                    mv = ($urandom_range(15) != 0);
                    if (level < 2) begin
                        v = $urandom_range(32767);
                    end else if (pred_prev_mm < 1 || pred_prev_mm >= level) begin
                        v = $urandom_range(level - 1, 1);
                    end else begin
                        case ($urandom_range(7))
                            0: off = e;
                            1: off = e + 1;
                            default: off = int'($urandom_range(2 * e)) - e;
                        endcase
                        if ($urandom_range(1)) off = -off;
                        v = pred_prev_mm + off;
                        if (v < 1) v = 1;
                        if (v > level - 1) v = level - 1;
                    end
                end
                RUN_EDGE: begin
                    case ($urandom_range(9))
                        0: v = 0;
                        1: v = 1;
                        2: v = -1;
                        3: v = level - 1;
                        4: v = level;
                        5: v = level + 1;
                        6: v = 32767;
                        7: v = -32768;
                        8: v = pred_prev_mm + e;
                        default: v = pred_prev_mm - e - 1;
                    endcase
                end
                default: v = $urandom_range(65535);
            endcase
            send_reading(v[READING_W-1:0], mv);
        end
    endtask

    // Strings of random runs, weighted toward the sequences that build up counters.
    task automatic send_traffic(input int n);
        int start;
        run_kind_t kind;
        start = readings_sent;
        while (readings_sent - start < n) begin
            case ($urandom_range(19))
                0, 1, 2:             kind = RUN_ERROR;
                3, 4:                kind = RUN_ZERO;
                5, 6, 7:             kind = RUN_FAR;
                8, 9, 10, 11, 12, 13: kind = RUN_STEADY;
                14, 15, 16:          kind = RUN_EDGE;
                default:             kind = RUN_NOISE;
            endcase
            send_run(kind, $urandom_range(24, 1));
        end
    endtask

    // Directed readings under the reset thresholds, starting with no history.
    task automatic test_reset_thresholds();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // The first reading is close to the cleared history but must not count.
        send_reading(16'sd1, 1'b1);
        send_reading(16'sd2, 1'b1);
        send_reading(16'sd3, 1'b1);
        send_reading(16'sd3, 1'b0);
        // Three error readings reach the fault limit.
        send_reading(-16'sd32768, 1'b1);
        send_reading(-16'sd1, 1'b0);
        send_reading(-16'sd2, 1'b1);
        // Far readings around the no-target level.
        send_reading(16'sd32767, 1'b1);
        send_reading(16'sd9999, 1'b0);
        send_reading(16'sd9998, 1'b1);
        send_reading(16'sd10000, 1'b1);
        send_reading(16'sd32767, 1'b0);
        send_reading(16'sd9999, 1'b1);
        send_reading(16'sd20000, 1'b1);
        // Zero readings reach the no-target limit.
        send_reading(16'sd0, 1'b1);
        send_reading(16'sd0, 1'b0);
        send_reading(16'sd0, 1'b1);
        send_reading(16'sd0, 1'b1);
        send_reading(-16'sd1, 1'b1);
        send_reading(16'sh5555, 1'b1);
        send_reading(16'shAAAA, 1'b0);
    endtask

    // Extreme threshold settings, including zero limits and oversized limit data.
    task automatic test_threshold_extremes();
        sender_idle_pct = 12;
        receiver_stall_pct = 12;
        apply_thresholds(15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        send_traffic(10);
        apply_thresholds(15'd32767, 15'd32767, 15'd255, 15'd255, 15'd255);
        send_traffic(10);
        apply_thresholds(15'd1, 15'd0, 15'd1, 15'd1, 15'd1);
        send_traffic(10);
        apply_thresholds(15'd32767, 15'd0, 15'd1, 15'd2, 15'd1);
        send_traffic(10);
        apply_thresholds(15'd100, 15'd32767, 15'd2, 15'd3, 15'd255);
        send_traffic(10);
        apply_thresholds(15'd5000, 15'd5, 15'h7F01, 15'h0100, 15'h7FFF);
        send_traffic(10);
    endtask

    // A zero run longer than the counter range, with every limit at its top
    // value; a no-target level of zero makes the zero and far runs saturate together.
    task automatic test_counter_saturation();
        sender_idle_pct = 0;
        receiver_stall_pct = 65;
        apply_thresholds(15'd0, 15'd2, 15'd255, 15'd255, 15'd255);
        send_run(RUN_ZERO, 260);
    endtask

    // Random runs under random thresholds, through every idling phase.
    task automatic test_random_traffic();
        int sender_pcts[4]   = '{0, 65, 0, 12};
        int receiver_pcts[4] = '{0, 0, 65, 12};
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = sender_pcts[p];
            receiver_stall_pct = receiver_pcts[p];
            randomize_thresholds();
            send_traffic(15);
            randomize_thresholds();
            send_traffic(15);
        end
    endtask

    // Receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each verdict with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict with none expected, status %0d health %0d",
                         $time, m_status, m_health);
                mismatch_count++;
            end else begin
                verdict_t exp_v;
                exp_v = expected_verdicts.pop_front();
                verdicts_checked++;
                if (m_status !== exp_v.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_v.status, m_status);
                    mismatch_count++;
                end
                if (m_health !== exp_v.health) begin
                    $display("%0t: health mismatch, expected %0d, actual %0d",
                             $time, exp_v.health, m_health);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if no channel makes progress for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d verdicts outstanding",
                     $time, WATCHDOG_LIMIT, expected_verdicts.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_thresholds();
        test_threshold_extremes();
        test_counter_saturation();
        test_random_traffic();
        drain_pipeline();
        $display("Sent %0d readings and checked %0d verdicts across %0d register writes,",
                 readings_sent, verdicts_checked, register_writes);
        $display("covering reset and extreme thresholds, saturated runs and four idling mixes.");
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
